// ===== design/mtis_pkg.sv =====
// ----------------------------------------------------------------------------
// mtis_pkg
// Shared defaults for the median-then-average smoother.
// ----------------------------------------------------------------------------
package mtis_pkg;

  // Default window length in samples
  localparam int unsigned WindowDef     = 5;
  // Default sample width in bits
  localparam int unsigned SampleBitsDef = 10;

endpackage

// ===== design/mtis_ring.sv =====
// ----------------------------------------------------------------------------
// mtis_ring
// Sample window with a downward-stepping write slot. It presents the window
// as it stands once the incoming sample is written, so the median can be
// taken in the cycle of the request.
// ----------------------------------------------------------------------------
module mtis_ring import mtis_pkg::*; #(
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   wr_en_i,
  input  logic [SAMPLE_BITS-1:0]                 sample_i,
  output logic [WINDOW-1:0][SAMPLE_BITS-1:0]     window_o
);

  localparam int unsigned SlotW = $clog2(WINDOW);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW - 1);

  logic [WINDOW-1:0][SAMPLE_BITS-1:0] ring_q;
  logic [SlotW-1:0]                   slot_q;
  logic [SlotW-1:0]                   slot_d;

  // Overlay the incoming sample on its slot
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      if (slot_q == SlotW'(k)) begin
        window_o[k] = sample_i;
      end else begin
        window_o[k] = ring_q[k];
      end
    end
  end

  // Step the slot downward and wrap to the top
  assign slot_d = (slot_q == '0) ? LastSlot : slot_q - SlotW'(1);

  // Hold the window; advance on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      slot_q <= '0;
    end else if (wr_en_i) begin
      ring_q <= window_o;
      slot_q <= slot_d;
    end
  end

endmodule

// ===== design/mtis_median.sv =====
// ----------------------------------------------------------------------------
// mtis_median
// Rank network: each entry counts the entries below it (ties broken by slot
// index) and the entry whose rank is the middle one is selected.
// ----------------------------------------------------------------------------
module mtis_median import mtis_pkg::*; #(
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic [WINDOW-1:0][SAMPLE_BITS-1:0] window_i,
  output logic [SAMPLE_BITS-1:0]             median_o
);

  localparam int unsigned RankW = $clog2(WINDOW);
  localparam logic [RankW-1:0] MidRank = RankW'(WINDOW / 2);

  logic [WINDOW-1:0][RankW-1:0] rank;
  logic [WINDOW-1:0]            below;

  // Count, for every entry, the entries ranked ahead of it
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        below[j] = (window_i[j] < window_i[i]) ||
                   ((window_i[j] == window_i[i]) && (j < i));
        rank[i]  = rank[i] + RankW'(below[j]);
      end
    end
  end

  // Ranks form a permutation, so exactly one entry matches the middle
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == MidRank) begin
        median_o = median_o | window_i[i];
      end
    end
  end

endmodule

// ===== design/median_then_iir_smoother_top.sv =====
// ----------------------------------------------------------------------------
// median_then_iir_smoother_top
// Each accepted sample enters a WINDOW-entry ring; the block returns the
// median of the ring and an exponentially smoothed value (doubled average
// updated as median + old/2, reported halved). The ring and the average
// start at zero, so the first medians include those zeros. A request is
// taken every cycle while the input is ready: each sample's result appears
// in the output register in the cycle after it is taken, computed by a
// single pass through the rank network and the average adder, and the
// input stays ready while that register is empty or being emptied.
// ----------------------------------------------------------------------------
module median_then_iir_smoother_top import mtis_pkg::*; #(
  parameter int unsigned WINDOW      = WindowDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_valid_i,
  output logic                   sample_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output logic [SAMPLE_BITS-1:0] median_o,
  output logic [SAMPLE_BITS-1:0] smoothed_o
);

  localparam int unsigned AvgW = SAMPLE_BITS + 1;
  localparam logic [AvgW-1:0] AvgMax = {{(SAMPLE_BITS){1'b1}}, 1'b0};

  logic                                   accept;
  logic [WINDOW-1:0][SAMPLE_BITS-1:0]     window;
  logic [SAMPLE_BITS-1:0]                 median;
  logic [AvgW-1:0]                        avg_q;
  logic [AvgW-1:0]                        avg_d;
  logic                                   out_valid_q;
  logic [SAMPLE_BITS-1:0]                 median_q;
  logic [SAMPLE_BITS-1:0]                 smoothed_q;

  // Take a request whenever the output register is free or draining
  assign sample_ready_o = !out_valid_q || result_ready_i;
  assign accept         = sample_valid_i && sample_ready_o;

  mtis_ring #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept),
    .sample_i (sample_i),
    .window_o (window)
  );

  mtis_median #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_median (
    .window_i (window),
    .median_o (median)
  );

  // Update the doubled average: median plus half the old value
  assign avg_d = AvgW'({1'b0, median} + {1'b0, avg_q[AvgW-1:1]});

  // Hold the average between requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (accept) begin
      avg_q <= avg_d;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sample_ready_o) begin
      out_valid_q <= sample_valid_i;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q   <= median;
      smoothed_q <= avg_d[AvgW-1:1];
    end
  end

  assign result_valid_o = out_valid_q;
  assign median_o       = median_q;
  assign smoothed_o     = smoothed_q;

  // An accepted request always shows a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted sample produced no result");

  // The doubled average never exceeds twice the largest sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_q <= AvgMax)
    else $error("doubled average out of range");

  // The average moves only on a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(avg_q))
    else $error("average changed without a request");

endmodule
